@@ hw/rtl/mkdb_pkg.sv @@
// ----------------------------------------------------------------------------
// mkdb_pkg
// Shared constants and types for the multi-key debounce / hold detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mkdb_pkg;

    localparam int NUM_KEYS_DEF  = 7;
    localparam int TIMER_W       = 8;
    localparam int HOLD_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_MIN_W     = 16;

    // paging keys that together form the volume gesture
    localparam int PAGE_UP_KEY   = 2;
    localparam int PAGE_DOWN_KEY = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TMO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MASK  = 3'd4;

    // reset values
    localparam logic [TIMER_W-1:0] TICK_MS_RST     = 8'd20;
    localparam logic [TIMER_W-1:0] DEBOUNCE_MS_RST = 8'd60;
    localparam logic [HOLD_W-1:0]  HOLD_TMO_RST    = 16'd5000;
    localparam logic [31:0]        PRESS_MASK_RST  = 32'd31;
    localparam logic [31:0]        HOLD_MASK_RST   = 32'd12;

    // per-key result handed from a lane to the merge stage
    typedef struct packed {
        logic press;      // press accepted this tick
        logic hold;       // hold timeout fired this tick
        logic level;      // debounced level after this tick
        logic old_level;  // debounced level before this tick
    } t_lane_res;

endpackage

`default_nettype wire

@@ hw/rtl/mkdb_lane.sv @@
// ----------------------------------------------------------------------------
// mkdb_lane
// Debounce and hold timing for one key, updated once per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mkdb_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_level,
    input  wire logic [mkdb_pkg::TIMER_W-1:0]   i_tick_ms,
    input  wire logic [mkdb_pkg::TIMER_W-1:0]   i_debounce_ms,
    input  wire logic [mkdb_pkg::HOLD_W-1:0]    i_hold_timeout_ms,
    input  wire logic                           i_press_en,
    input  wire logic                           i_hold_en,
    output mkdb_pkg::t_lane_res                 o_res
);

    logic                          r_stable,  n_stable;
    logic [mkdb_pkg::TIMER_W-1:0]  r_change,  n_change;
    logic [mkdb_pkg::TIMER_W-1:0]  r_recover, n_recover;
    logic [mkdb_pkg::HOLD_W-1:0]   r_hold,    n_hold;

    logic [mkdb_pkg::TIMER_W:0]    sum_change, sum_recover;
    logic [mkdb_pkg::TIMER_W-1:0]  change_inc, recover_inc;
    logic [mkdb_pkg::HOLD_W-1:0]   hold_inc;
    logic                          press, hold;

    // saturating 8-bit adds, wrapping 16-bit hold add
    assign sum_change  = {1'b0, r_change}  + {1'b0, i_tick_ms};
    assign sum_recover = {1'b0, r_recover} + {1'b0, i_tick_ms};
    assign change_inc  = sum_change[mkdb_pkg::TIMER_W]  ? '1
                                                        : sum_change[mkdb_pkg::TIMER_W-1:0];
    assign recover_inc = sum_recover[mkdb_pkg::TIMER_W] ? '1
                                                        : sum_recover[mkdb_pkg::TIMER_W-1:0];
    assign hold_inc    = r_hold + {{(mkdb_pkg::HOLD_W-mkdb_pkg::TIMER_W){1'b0}}, i_tick_ms};

    always_comb begin
        n_stable  = r_stable;
        n_change  = r_change;
        n_recover = r_recover;
        n_hold    = r_hold;
        press     = 1'b0;
        hold      = 1'b0;
        if (i_level != r_stable) begin
            n_change = change_inc;
            if (change_inc >= i_debounce_ms) begin
                n_stable = i_level;
                n_change = '0;
                press    = ~i_level & i_press_en;
            end
            n_recover = '0;
        end else begin
            if (r_recover >= i_debounce_ms) begin
                n_change = '0;
            end else if (r_change != '0) begin
                n_recover = recover_inc;
            end
            if (!r_stable) begin
                n_change = '0;
                n_hold   = hold_inc;
                if (i_hold_en && (hold_inc >= i_hold_timeout_ms)) begin
                    n_hold = '0;
                    hold   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable  <= 1'b1;
            r_change  <= '0;
            r_recover <= '0;
            r_hold    <= '0;
        end else if (i_accept) begin
            r_stable  <= n_stable;
            r_change  <= n_change;
            r_recover <= n_recover;
            r_hold    <= n_hold;
        end
    end

    assign o_res.press     = press;
    assign o_res.hold      = hold;
    assign o_res.level     = n_stable;
    assign o_res.old_level = r_stable;

endmodule

`default_nettype wire

@@ hw/rtl/mkdb_merge.sv @@
// ----------------------------------------------------------------------------
// mkdb_merge
// Gathers lane results into event words, forms the volume event and holds
// the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mkdb_merge #(
    parameter int NUM_KEYS = mkdb_pkg::NUM_KEYS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  mkdb_pkg::t_lane_res       i_res [NUM_KEYS],
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [NUM_KEYS-1:0]       o_press_events,
    output logic [NUM_KEYS-1:0]       o_hold_events,
    output logic                      o_volume_event,
    output logic [NUM_KEYS-1:0]       o_debounced_levels
);

    logic [NUM_KEYS-1:0] press_w, hold_w, level_w, old_w;
    logic                vol_w;
    logic                r_out_valid;
    logic [NUM_KEYS-1:0] r_press, r_hold, r_level;
    logic                r_vol;

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            press_w[k] = i_res[k].press;
            hold_w[k]  = i_res[k].hold;
            level_w[k] = i_res[k].level;
            old_w[k]   = i_res[k].old_level;
        end
    end

    // keys update in ascending order: page-up sees page-down before its
    // update, page-down sees page-up after its update
    assign vol_w = (hold_w[mkdb_pkg::PAGE_UP_KEY]   & ~old_w[mkdb_pkg::PAGE_DOWN_KEY]) |
                   (hold_w[mkdb_pkg::PAGE_DOWN_KEY] & ~level_w[mkdb_pkg::PAGE_UP_KEY]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_press <= press_w;
            r_hold  <= hold_w;
            r_level <= level_w;
            r_vol   <= vol_w;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_press_events     = r_press;
    assign o_hold_events      = r_hold;
    assign o_volume_event     = r_vol;
    assign o_debounced_levels = r_level;

endmodule

`default_nettype wire

@@ hw/rtl/multi_key_debounce_hold_detect.sv @@
// ----------------------------------------------------------------------------
// multi_key_debounce_hold_detect
// Debounces a bank of active-low keys and reports presses, long holds and
// the two-key volume gesture, one result per tick request.
//
// Each input request is one timer tick carrying the raw levels of all keys
// (0 = pressed). One lane per key keeps its debounced level, mismatch timer,
// recovery timer and hold timer, all lanes updating in the same clock; a
// merge stage forms the event words and the volume flag and loads them into
// an output register. A result is valid the cycle after its request is
// taken, and a new tick is accepted every cycle as long as the output
// side is not stalling a waiting result. Registers (tick_ms, debounce_ms,
// hold_timeout_ms, press_enable_mask, hold_enable_mask) are written
// through the cfg port, which is always ready; write them only while no
// result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_key_debounce_hold_detect #(
    parameter int NUM_KEYS = mkdb_pkg::NUM_KEYS_DEF,
    localparam int CFG_DATA_W = (NUM_KEYS > mkdb_pkg::CFG_MIN_W) ? NUM_KEYS
                                                                 : mkdb_pkg::CFG_MIN_W
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tick requests
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [NUM_KEYS-1:0]             i_key_levels,
    // results
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [NUM_KEYS-1:0]                  o_press_events,
    output logic [NUM_KEYS-1:0]                  o_hold_events,
    output logic                                 o_volume_event,
    output logic [NUM_KEYS-1:0]                  o_debounced_levels,
    // register writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mkdb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]           i_cfg_data
);

    logic [mkdb_pkg::TIMER_W-1:0] r_tick_ms;
    logic [mkdb_pkg::TIMER_W-1:0] r_debounce_ms;
    logic [mkdb_pkg::HOLD_W-1:0]  r_hold_tmo;
    logic [NUM_KEYS-1:0]          r_press_en;
    logic [NUM_KEYS-1:0]          r_hold_en;

    logic                         accept;
    mkdb_pkg::t_lane_res          lane_res [NUM_KEYS];

    // ---- register file ---------------------------------------------------
    // Unknown indexes are dropped silently.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms     <= mkdb_pkg::TICK_MS_RST;
            r_debounce_ms <= mkdb_pkg::DEBOUNCE_MS_RST;
            r_hold_tmo    <= mkdb_pkg::HOLD_TMO_RST;
            r_press_en    <= mkdb_pkg::PRESS_MASK_RST[NUM_KEYS-1:0];
            r_hold_en     <= mkdb_pkg::HOLD_MASK_RST[NUM_KEYS-1:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mkdb_pkg::CFG_TICK_MS:    r_tick_ms     <= i_cfg_data[mkdb_pkg::TIMER_W-1:0];
                mkdb_pkg::CFG_DEBOUNCE:   r_debounce_ms <= i_cfg_data[mkdb_pkg::TIMER_W-1:0];
                mkdb_pkg::CFG_HOLD_TMO:   r_hold_tmo    <= i_cfg_data[mkdb_pkg::HOLD_W-1:0];
                mkdb_pkg::CFG_PRESS_MASK: r_press_en    <= i_cfg_data[NUM_KEYS-1:0];
                mkdb_pkg::CFG_HOLD_MASK:  r_hold_en     <= i_cfg_data[NUM_KEYS-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---- tick handshake --------------------------------------------------
    // Take a tick unless the output register holds a result that is stalled.
    assign o_in_stall = o_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    // ---- key lanes -------------------------------------------------------
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        mkdb_lane u_lane (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_accept          (accept),
            .i_level           (i_key_levels[k]),
            .i_tick_ms         (r_tick_ms),
            .i_debounce_ms     (r_debounce_ms),
            .i_hold_timeout_ms (r_hold_tmo),
            .i_press_en        (r_press_en[k]),
            .i_hold_en         (r_hold_en[k]),
            .o_res             (lane_res[k])
        );
    end

    // ---- merge and output register ---------------------------------------
    mkdb_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_res              (lane_res),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_press_events     (o_press_events),
        .o_hold_events      (o_hold_events),
        .o_volume_event     (o_volume_event),
        .o_debounced_levels (o_debounced_levels)
    );

    // ---- checks ----------------------------------------------------------
    // every taken tick shows up in the output register next cycle
    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("tick taken but no result registered");

    // a press is only reported on a key that now reads pressed
    a_press_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_press_events & o_debounced_levels) == '0))
        else $error("press event on a released key");

    // holds only come from hold-enabled keys
    a_hold_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_hold_events & ~r_hold_en) == '0))
        else $error("hold event on a key without hold enable");

    // volume needs a hold on one of the paging keys
    a_volume_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_volume_event) |->
            (o_hold_events[mkdb_pkg::PAGE_UP_KEY] || o_hold_events[mkdb_pkg::PAGE_DOWN_KEY]))
        else $error("volume event without a paging-key hold");

endmodule

`default_nettype wire

@@ dv/multi_key_debounce_hold_detect_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_key_debounce_hold_detect_tb
// Self-checking bench for the key debounce / long-press detector. A tracker
// class mirrors every key's debounce, recovery and hold timers. It predicts
// one report per tick request and compares the reports as they come out.
// Stimulus is short directed runs followed by random key activity (steady
// presses with bounce and noise) under several register settings, the
// extremes among them. Both handshakes idle at random.
// ----------------------------------------------------------------------------

module multi_key_debounce_hold_detect_tb;

    localparam int NK = mkdb_pkg::NUM_KEYS_DEF;
    localparam int CFG_W = (NK > mkdb_pkg::CFG_MIN_W) ? NK : mkdb_pkg::CFG_MIN_W;
    localparam int IDX_W = mkdb_pkg::CFG_IDX_W;
    localparam int WATCHDOG_LIMIT = 2000;

    // indexes with no register behind them, writes must be dropped
    localparam logic [IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [NK-1:0] press;
        logic [NK-1:0] hold;
        logic          volume;
        logic [NK-1:0] levels;
    } t_key_report;

    // one register setting plus the shape of the key activity under it
    typedef struct {
        logic [7:0]    tick;
        logic [7:0]    debounce;
        logic [15:0]   hold_tmo;
        logic [NK-1:0] press_mask;
        logic [NK-1:0] hold_mask;
        int            churn;      // per-mille chance per tick that a key flips
        int            items;
        logic [NK-1:0] start;      // intended levels at phase start
    } t_phase;

    // ------------------------------------------------------------------------
    // Tracker: per-key timers and register copies, queue of expected reports
    // ------------------------------------------------------------------------
    class keypad_tracker;
        logic [7:0]    tick_ms;
        logic [7:0]    debounce_ms;
        logic [15:0]   hold_tmo;
        logic [NK-1:0] press_mask;
        logic [NK-1:0] hold_mask;
        logic [NK-1:0] level;
        logic [7:0]    mismatch_t [NK];
        logic [7:0]    recover_t  [NK];
        logic [15:0]   held_t     [NK];
        t_key_report   pending_reports[$];
        int            errors;
        int            ticks;
        int            presses;
        int            holds;
        int            volumes;

        function new();
            tick_ms     = mkdb_pkg::TICK_MS_RST;
            debounce_ms = mkdb_pkg::DEBOUNCE_MS_RST;
            hold_tmo    = mkdb_pkg::HOLD_TMO_RST;
            press_mask  = mkdb_pkg::PRESS_MASK_RST[NK-1:0];
            hold_mask   = mkdb_pkg::HOLD_MASK_RST[NK-1:0];
            level       = '1;
            foreach (mismatch_t[k]) begin
                mismatch_t[k] = '0;
                recover_t[k]  = '0;
                held_t[k]     = '0;
            end
            errors  = 0;
            ticks   = 0;
            presses = 0;
            holds   = 0;
            volumes = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                mkdb_pkg::CFG_TICK_MS:    tick_ms     = data[7:0];
                mkdb_pkg::CFG_DEBOUNCE:   debounce_ms = data[7:0];
                mkdb_pkg::CFG_HOLD_TMO:   hold_tmo    = data[15:0];
                mkdb_pkg::CFG_PRESS_MASK: press_mask  = data[NK-1:0];
                mkdb_pkg::CFG_HOLD_MASK:  hold_mask   = data[NK-1:0];
                default: ;
            endcase
        endfunction

        // mismatch and recovery timers stick at all ones
        function logic [7:0] sat_add(logic [7:0] a, logic [7:0] b);
            logic [8:0] s;
            s = a + b;
            return s[8] ? 8'hFF : s[7:0];
        endfunction

        // keys are walked in ascending order; the volume test sees the other
        // paging key's level as already updated only if it has a lower index
        function void note_tick(logic [NK-1:0] raw);
            t_key_report r;
            r = '0;
            for (int k = 0; k < NK; k++) begin
                if (raw[k] != level[k]) begin
                    mismatch_t[k] = sat_add(mismatch_t[k], tick_ms);
                    if (mismatch_t[k] >= debounce_ms) begin
                        level[k]      = raw[k];
                        mismatch_t[k] = '0;
                        if (!raw[k] && press_mask[k])
                            r.press[k] = 1'b1;
                    end
                    recover_t[k] = '0;
                end else begin
                    if (recover_t[k] >= debounce_ms)
                        mismatch_t[k] = '0;
                    else if (mismatch_t[k] != 0)
                        recover_t[k] = sat_add(recover_t[k], tick_ms);
                    if (!level[k]) begin
                        mismatch_t[k] = '0;
                        held_t[k]     = held_t[k] + tick_ms;   // wraps at 16 bits
                        if (hold_mask[k] && held_t[k] >= hold_tmo) begin
                            held_t[k] = '0;
                            r.hold[k] = 1'b1;
                            if (k == mkdb_pkg::PAGE_UP_KEY &&
                                !level[mkdb_pkg::PAGE_DOWN_KEY])
                                r.volume = 1'b1;
                            if (k == mkdb_pkg::PAGE_DOWN_KEY &&
                                !level[mkdb_pkg::PAGE_UP_KEY])
                                r.volume = 1'b1;
                        end
                    end
                end
                r.levels[k] = level[k];
            end
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [NK-1:0] want, logic [NK-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %h, got %h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_key_report got);
            t_key_report want;
            if (pending_reports.size() == 0) begin
                $display("%0t ns: unexpected report %h with nothing pending", $time, got);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            ticks++;
            presses += $countones(want.press);
            holds   += $countones(want.hold);
            volumes += want.volume;
            compare_field("press_events", want.press, got.press);
            compare_field("hold_events", want.hold, got.hold);
            compare_field("volume_event", NK'(want.volume), NK'(got.volume));
            compare_field("debounced_levels", want.levels, got.levels);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [NK-1:0]        i_key_levels = '1;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [NK-1:0]        o_press_events;
    logic [NK-1:0]        o_hold_events;
    logic                 o_volume_event;
    logic [NK-1:0]        o_debounced_levels;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    multi_key_debounce_hold_detect #(
        .NUM_KEYS (NK)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_key_levels       (i_key_levels),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_press_events     (o_press_events),
        .o_hold_events      (o_hold_events),
        .o_volume_event     (o_volume_event),
        .o_debounced_levels (o_debounced_levels),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    keypad_tracker tracker = new();
    bit idle_on = 1'b1;     // cleared for the stretch with no idling at all
    int settings_used = 1;  // reset values count as the first setting
    int quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Result side: values are read right after the edge, i.e. the values the
    // DUT saw at that edge, so no race with the DUT's own flops.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            tracker.check_report({o_press_events, o_hold_events, o_volume_event,
                                  o_debounced_levels});
        i_out_stall <= idle_on && ($urandom_range(0, 99) < 7);

        // watchdog: any handshake on any channel counts as progress
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Leaves valid high on return; the caller either sends the next tick in
    // the same step or lowers valid itself.
    task automatic send_tick(input logic [NK-1:0] lv);
        if (idle_on && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_key_levels <= lv;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_tick(lv);
    endtask

    // stop sending and wait until every expected report has been seen
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    // Registers change only with the block idle. Upper data bits are random
    // so the write masking gets exercised; one write goes to a dead index.
    task automatic configure(input t_phase p);
        logic [CFG_W-1:0] junk;
        drain_reports();
        repeat (2) @(posedge i_clk);
        junk = CFG_W'($urandom);
        write_reg(mkdb_pkg::CFG_TICK_MS,    {junk[CFG_W-1:8], p.tick});
        write_reg(mkdb_pkg::CFG_DEBOUNCE,   {junk[CFG_W-1:8], p.debounce});
        write_reg(mkdb_pkg::CFG_HOLD_TMO,   CFG_W'(p.hold_tmo));
        write_reg(mkdb_pkg::CFG_PRESS_MASK, {junk[CFG_W-1:NK], p.press_mask});
        write_reg(mkdb_pkg::CFG_HOLD_MASK,  {~junk[CFG_W-1:NK], p.hold_mask});
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, CFG_W'($urandom));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random key activity: each key follows an intended level that flips now
    // and then (paging keys often move together), plus contact bounce on
    // single bits and the odd tick of pure noise.
    task automatic run_phase(input t_phase p, input bit pause_midway);
        logic [NK-1:0] intended;
        logic [NK-1:0] lv;
        intended = p.start;
        for (int n = 0; n < p.items; n++) begin
            for (int k = 0; k < NK; k++)
                if ($urandom_range(0, 999) < p.churn)
                    intended[k] = ~intended[k];
            if ($urandom_range(0, 3) == 0)
                intended[mkdb_pkg::PAGE_DOWN_KEY] = intended[mkdb_pkg::PAGE_UP_KEY];
            if ($urandom_range(0, 15) == 0)
                lv = NK'($urandom);
            else begin
                lv = intended;
                for (int k = 0; k < NK; k++)
                    if ($urandom_range(0, 31) == 0)
                        lv[k] = ~lv[k];
            end
            send_tick(lv);
            if (pause_midway && n == p.items / 2)
                drain_reports();
        end
        i_in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [NK-1:0] directed_lv [$];
        t_phase        ph [$];
        t_phase        p;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: clean press of every key, a bounce that must be
        // forgotten, release, then alternating key patterns.
        directed_lv = '{7'h7F, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
                        7'h7F, 7'h00, 7'h00, 7'h7F, 7'h7F, 7'h7F,
                        7'h55, 7'h55, 7'h55, 7'h2A, 7'h2A, 7'h2A, 7'h7F};
        foreach (directed_lv[i])
            send_tick(directed_lv[i]);
        i_in_valid <= 1'b0;

        // Zero hold timeout with both paging keys down: hold fires on every
        // steady tick and the pair raises the volume gesture.
        p = '{tick: 8'd30, debounce: 8'd60, hold_tmo: 16'd0, press_mask: 7'h7F,
              hold_mask: 7'h0C, churn: 0, items: 0, start: 7'h7F};
        configure(p);
        directed_lv = '{7'h73, 7'h73, 7'h73, 7'h73, 7'h7F, 7'h7F};
        foreach (directed_lv[i])
            send_tick(directed_lv[i]);
        i_in_valid <= 1'b0;

        // all registers at their top values, long presses reach the timeout
        ph.push_back('{8'd255, 8'd255, 16'hFFFF, 7'h7F, 7'h7F, 3, 280, 7'h00});
        // smallest nonzero tick and debounce, zero timeout and masks; nothing is hold-enabled
        ph.push_back('{8'd1, 8'd1, 16'd0, 7'h00, 7'h00, 60, 90, 7'h7F});
        // zero tick and zero debounce taken as given
        ph.push_back('{8'd0, 8'd0, 16'(40), NK'($urandom), NK'($urandom), 80, 90, 7'h7F});
        // timers pushed into saturation, every key hold-enabled
        ph.push_back('{8'd200, 8'd255, 16'd0, 7'h7F, 7'h7F, 50, 90, 7'h7F});
        // hold timer wraps on keys that never fire
        ph.push_back('{8'd254, 8'd255, 16'hFFFF, 7'h7F, 7'h00, 2, 300, 7'h00});
        repeat (4)
            ph.push_back('{8'($urandom_range(1, 40)), 8'($urandom_range(1, 120)),
                           16'($urandom_range(0, 800)), NK'($urandom),
                           NK'($urandom) | 7'h0C, $urandom_range(10, 80), 90, 7'h7F});

        foreach (ph[i]) begin
            configure(ph[i]);
            idle_on = (i != 5);          // one phase runs with no idling at all
            run_phase(ph[i], i == 6);    // one phase stops midway to drain
            idle_on = 1'b1;
        end

        while (tracker.pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (tracker.pending_reports.size() != 0) begin
            $display("%0d expected reports never arrived", tracker.pending_reports.size());
            tracker.errors++;
        end
        $display("checked %0d ticks under %0d register settings", tracker.ticks,
                 settings_used);
        $display("seen %0d presses, %0d holds, %0d volume gestures",
                 tracker.presses, tracker.holds, tracker.volumes);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
